/* design/epsu_pkg.sv */
// Shared constants and codes for the embedding pair update engine.
// No dependencies; used by every module of the block.
`default_nettype none

package epsu_pkg;

  localparam int NODE_COUNT_DEF      = 1024;
  localparam int DIM_MAX_DEF         = 128;
  localparam int SIGMOID_ENTRIES_DEF = 1024;

  localparam int WORD_W   = 32;
  localparam int STEP_W   = 26;
  localparam int LR_W     = 24;
  localparam int DIMREG_W = 8;
  localparam int NODE_W   = 10;
  localparam int EL_W     = 7;
  localparam int CMD_W    = 2;
  localparam int SIG_W    = 17;
  localparam int DIFF_W   = 18;

  localparam int IN_DATA_W  = 96;
  localparam int OUT_DATA_W = 64;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 24;

  localparam logic [CMD_W-1:0] CMD_LOAD   = 2'd0;
  localparam logic [CMD_W-1:0] CMD_READ   = 2'd1;
  localparam logic [CMD_W-1:0] CMD_UPDATE = 2'd2;

  localparam logic [CFG_IDX_W-1:0] REG_LEARNING_RATE = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_DIMENSION     = 1'b1;

  localparam logic [LR_W-1:0]     LR_RESET  = 24'd41943;
  localparam logic [DIMREG_W-1:0] DIM_RESET = 8'd128;

  // 6.0 in Q.24
  localparam longint SCORE_BOUND = 64'd100663296;
  localparam logic [SIG_W-1:0] SIG_ONE = 17'h10000;

endpackage

`default_nettype wire

/* design/epsu_ram.sv */
// Generic simple dual-read RAM: one write port, two registered read ports.
// Depends on epsu_pkg for its default parameters.
`default_nettype none

module epsu_ram #(
  parameter int WIDTH  = epsu_pkg::WORD_W,
  parameter int DEPTH  = epsu_pkg::NODE_COUNT_DEF * epsu_pkg::DIM_MAX_DEF,
  parameter int ADDR_W = $clog2(DEPTH)
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic [ADDR_W-1:0] raddr_a,
  input  logic [ADDR_W-1:0] raddr_b,
  output logic [WIDTH-1:0]  rdata_a,
  output logic [WIDTH-1:0]  rdata_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_a <= mem[raddr_a];
    rdata_b <= mem[raddr_b];
  end

endmodule

`default_nettype wire

/* design/epsu_sigmoid.sv */
// Pipelined sigmoid lookup: range check, table index scaling, ROM read.
// Depends on epsu_pkg.
`default_nettype none

module epsu_sigmoid #(
  parameter int SIGMOID_ENTRIES = epsu_pkg::SIGMOID_ENTRIES_DEF,
  parameter int ACC_W           = 49
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic signed [ACC_W-1:0]       score,
  output logic                          valid,
  output logic [epsu_pkg::SIG_W-1:0]    value
);
  import epsu_pkg::*;

  localparam int K_W = $clog2(SIGMOID_ENTRIES);
  localparam logic signed [ACC_W-1:0] BOUND_S = ACC_W'(SCORE_BOUND);
  localparam logic signed [ACC_W-1:0] NBOUND_S = -BOUND_S;

  logic [15:0] rom [SIGMOID_ENTRIES];

  // Table built at elaboration: 31-bit fraction exponential, then rounded.
  for (genvar k = 0; k < SIGMOID_ENTRIES; k++) begin : g_rom
    localparam logic [63:0] ONE = 64'd1 << 31;
    localparam logic [63:0] MID = 64'd6 << 31;
    localparam logic [63:0] XP  = ((64'(k) * 64'd12) << 31) / SIGMOID_ENTRIES;
    localparam bit          NEG = XP < MID;
    localparam logic [63:0] U   = (NEG ? MID - XP : XP - MID) >> 6;
    localparam logic [63:0] T1  = ((ONE * U) >> 31) / 1;
    localparam logic [63:0] E1  = ONE - T1;
    localparam logic [63:0] T2  = ((T1 * U) >> 31) / 2;
    localparam logic [63:0] E2  = E1 + T2;
    localparam logic [63:0] T3  = ((T2 * U) >> 31) / 3;
    localparam logic [63:0] E3  = E2 - T3;
    localparam logic [63:0] T4  = ((T3 * U) >> 31) / 4;
    localparam logic [63:0] E4  = E3 + T4;
    localparam logic [63:0] T5  = ((T4 * U) >> 31) / 5;
    localparam logic [63:0] E5  = E4 - T5;
    localparam logic [63:0] T6  = ((T5 * U) >> 31) / 6;
    localparam logic [63:0] E6  = E5 + T6;
    localparam logic [63:0] Q1  = (E6 * E6) >> 31;
    localparam logic [63:0] Q2  = (Q1 * Q1) >> 31;
    localparam logic [63:0] Q3  = (Q2 * Q2) >> 31;
    localparam logic [63:0] Q4  = (Q3 * Q3) >> 31;
    localparam logic [63:0] Q5  = (Q4 * Q4) >> 31;
    localparam logic [63:0] Q6  = (Q5 * Q5) >> 31;
    localparam logic [63:0] DEN = ONE + Q6;
    localparam logic [63:0] SIG = NEG ? (((Q6 << 16) + DEN / 2) / DEN)
                                      : (((ONE << 16) + DEN / 2) / DEN);
    assign rom[k] = SIG[15:0];
  end

  logic              v1_r, v2_r, v3_r, v4_r;
  logic              hi1_r, lo1_r, hi2_r, lo2_r, hi3_r, lo3_r;
  logic [27:0]       sp_r;
  logic [15:0]       v_r;
  logic [K_W-1:0]    k_r;
  logic [SIG_W-1:0]  sig_r;
  logic [41:0]       xprod;
  logic [31:0]       qprod;
  logic [14:0]       kfull;
  logic [ACC_W-1:0]  shifted;

  assign shifted = score + BOUND_S;
  assign xprod   = 42'(sp_r) * 42'(SIGMOID_ENTRIES);
  // divide by three through its reciprocal; exact for these index values
  assign qprod   = 32'(v_r) * 32'd43691;
  assign kfull   = qprod[31:17];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
    end else begin
      v1_r <= start;
      v2_r <= v1_r;
      v3_r <= v2_r;
      v4_r <= v3_r;
    end
    hi1_r <= score > BOUND_S;
    lo1_r <= score < NBOUND_S;
    sp_r  <= shifted[27:0];
    hi2_r <= hi1_r;
    lo2_r <= lo1_r;
    v_r   <= xprod[41:26];
    hi3_r <= hi2_r;
    lo3_r <= lo2_r;
    if ({17'd0, kfull} >= 32'(SIGMOID_ENTRIES)) begin
      k_r <= K_W'(SIGMOID_ENTRIES - 1);
    end else begin
      k_r <= K_W'(kfull);
    end
    if (hi3_r) begin
      sig_r <= SIG_ONE;
    end else if (lo3_r) begin
      sig_r <= '0;
    end else begin
      sig_r <= {1'b0, rom[k_r]};
    end
  end

  assign valid = v4_r;
  assign value = sig_r;

endmodule

`default_nettype wire

/* design/embedding_pair_sgd_update.sv */
// Embedding pair update engine: load, read and negative-sampling SGD update.
// All commands: row numbers at or above NODE_COUNT are first folded by repeated subtraction.
// Pair update: a dot pass, the sigmoid lookup and step product, then a target pass and a
// source pass over the d elements in use, the three passes sharing the single multiplier.
// One item in work at a time; synchronous active-low reset restores control and register
// defaults, the embedding RAM is not cleared.
`default_nettype none

module embedding_pair_sgd_update #(
  parameter int NODE_COUNT      = epsu_pkg::NODE_COUNT_DEF,
  parameter int DIM_MAX         = epsu_pkg::DIM_MAX_DEF,
  parameter int SIGMOID_ENTRIES = epsu_pkg::SIGMOID_ENTRIES_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  // node_a, node_b, element_index, load_value, label, bias (from bit 0), zero pad
  input  logic [epsu_pkg::IN_DATA_W-1:0]    in_tdata,
  // command
  input  logic [epsu_pkg::CMD_W-1:0]        in_tuser,
  output logic                              out_tvalid,
  input  logic                              out_tready,
  // read_value, step_scale (from bit 0), zero pad
  output logic [epsu_pkg::OUT_DATA_W-1:0]   out_tdata,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [epsu_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [epsu_pkg::CFG_DATA_W-1:0]   cfg_data
);
  import epsu_pkg::*;

  localparam int DEPTH  = NODE_COUNT * DIM_MAX;
  localparam int ADDR_W = $clog2(DEPTH);
  localparam int CNT_W  = $clog2(DIM_MAX + 1);
  localparam int ACC_W  = 41 + $clog2(DIM_MAX + 1);

  typedef enum logic [12:0] {
    S_IDLE  = 13'h0001,
    S_RED   = 13'h0002,
    S_BASE  = 13'h0004,
    S_LOAD  = 13'h0008,
    S_READ  = 13'h0010,
    S_RWAIT = 13'h0020,
    S_DOT   = 13'h0040,
    S_SIG   = 13'h0080,
    S_STEP  = 13'h0100,
    S_STEPW = 13'h0200,
    S_TGT   = 13'h0400,
    S_SRC   = 13'h0800,
    S_FIN   = 13'h1000
  } state_t;

  typedef enum logic [1:0] {
    P_DOT = 2'd0,
    P_TGT = 2'd1,
    P_SRC = 2'd2
  } pass_t;

  state_t                  state_r, state_nxt;
  logic [CMD_W-1:0]        cmd_r;
  logic [NODE_W-1:0]       ra_r, rb_r;
  logic [EL_W-1:0]         el_r;
  logic [WORD_W-1:0]       lv_r, bias_r;
  logic                    label_r;
  logic [LR_W-1:0]         lr_r;
  logic [DIMREG_W-1:0]     dim_r;
  logic [ADDR_W-1:0]       base_a_r, base_b_r;
  logic [CNT_W-1:0]        dlen_r, cnt_r;
  logic signed [ACC_W-1:0] acc_r;
  logic [DIFF_W-1:0]       diff_r;
  logic [STEP_W-1:0]       step_r;
  logic [WORD_W-1:0]       rv_r;
  logic                    p1_v_r, p2_v_r;
  pass_t                   p1_pass_r, p2_pass_r, pass_cur;
  logic [CNT_W-1:0]        p1_c_r, p2_c_r;
  logic signed [63:0]      prod_r;
  logic [WORD_W-1:0]       add_r;
  logic                    out_valid_r;
  logic [WORD_W-1:0]       out_read_r;
  logic [STEP_W-1:0]       out_step_r;

  logic                    accept, issue, done, el_ok, red_a, red_b, fin_go;
  logic [ADDR_W-1:0]       rd_addr_a, rd_addr_b, wr_addr;
  logic                    we;
  logic [WORD_W-1:0]       wr_data, q_a, q_b;
  logic signed [31:0]      mul_a, mul_b;
  logic signed [63:0]      prod;
  logic signed [39:0]      sh;
  logic [40:0]             sum;
  logic [WORD_W-1:0]       sat;
  logic                    sig_start, sig_valid;
  logic [SIG_W-1:0]        sig_value;
  logic [CNT_W-1:0]        dlen_nxt;

  assign in_tready = (state_r == S_IDLE);
  assign accept    = in_tvalid && in_tready;
  assign cfg_ready = 1'b1;

  assign el_ok = {25'd0, el_r} < 32'(DIM_MAX);
  assign red_a = {22'd0, ra_r} >= 32'(NODE_COUNT);
  assign red_b = {22'd0, rb_r} >= 32'(NODE_COUNT);

  assign dlen_nxt = ({24'd0, dim_r} > 32'(DIM_MAX)) ? CNT_W'(DIM_MAX) : CNT_W'(dim_r);

  assign issue  = (state_r inside {S_DOT, S_TGT, S_SRC}) && (cnt_r < dlen_r);
  assign done   = (cnt_r == dlen_r) && !p1_v_r && !p2_v_r;
  assign fin_go = !out_valid_r || out_tready;

  always_comb begin
    pass_cur = P_DOT;
    if (state_r == S_TGT) begin
      pass_cur = P_TGT;
    end else if (state_r == S_SRC) begin
      pass_cur = P_SRC;
    end
  end

  assign rd_addr_a = (state_r == S_READ) ? base_a_r + ADDR_W'(el_r)
                                         : base_a_r + ADDR_W'(cnt_r);
  assign rd_addr_b = base_b_r + ADDR_W'(cnt_r);

  // shared multiplier: step product, dot terms and weight deltas
  always_comb begin
    if (state_r == S_STEP) begin
      mul_a = {{(32-DIFF_W){diff_r[DIFF_W-1]}}, diff_r};
      mul_b = {{(32-LR_W){1'b0}}, lr_r};
    end else begin
      case (p1_pass_r)
        P_DOT: begin
          mul_a = q_a;
          mul_b = q_b;
        end
        P_TGT: begin
          mul_a = {{(32-STEP_W){step_r[STEP_W-1]}}, step_r};
          mul_b = q_a;
        end
        default: begin
          mul_a = {{(32-STEP_W){step_r[STEP_W-1]}}, step_r};
          mul_b = q_b;
        end
      endcase
    end
  end

  assign prod = mul_a * mul_b;
  assign sh   = prod_r[63:24];
  assign sum  = {{9{add_r[31]}}, add_r} + {sh[39], sh};

  always_comb begin
    if (!sum[40] && (|sum[39:31])) begin
      sat = 32'h7FFF_FFFF;
    end else if (sum[40] && !(&sum[39:31])) begin
      sat = 32'h8000_0000;
    end else begin
      sat = sum[31:0];
    end
  end

  always_comb begin
    if (state_r == S_LOAD) begin
      we      = el_ok;
      wr_addr = base_a_r + ADDR_W'(el_r);
      wr_data = lv_r;
    end else begin
      we      = p2_v_r && (p2_pass_r != P_DOT);
      wr_addr = ((p2_pass_r == P_TGT) ? base_b_r : base_a_r) + ADDR_W'(p2_c_r);
      wr_data = sat;
    end
  end

  assign sig_start = (state_r == S_DOT) && done;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE:  if (accept) state_nxt = S_RED;
      S_RED:   if (!red_a && !red_b) state_nxt = S_BASE;
      S_BASE: begin
        case (cmd_r)
          CMD_LOAD:   state_nxt = S_LOAD;
          CMD_READ:   state_nxt = S_READ;
          CMD_UPDATE: state_nxt = S_DOT;
          default:    state_nxt = S_FIN;
        endcase
      end
      S_LOAD:  state_nxt = S_FIN;
      S_READ:  state_nxt = S_RWAIT;
      S_RWAIT: state_nxt = S_FIN;
      S_DOT:   if (done) state_nxt = S_SIG;
      S_SIG:   if (sig_valid) state_nxt = S_STEP;
      S_STEP:  state_nxt = S_STEPW;
      S_STEPW: state_nxt = S_TGT;
      S_TGT:   if (done) state_nxt = S_SRC;
      S_SRC:   if (done) state_nxt = S_FIN;
      S_FIN:   if (fin_go) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      p1_v_r      <= 1'b0;
      p2_v_r      <= 1'b0;
      out_valid_r <= 1'b0;
      lr_r        <= LR_RESET;
      dim_r       <= DIM_RESET;
    end else begin
      state_r <= state_nxt;
      p1_v_r  <= issue;
      p2_v_r  <= p1_v_r;
      if (state_r == S_FIN && fin_go) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
      if (cfg_valid) begin
        case (cfg_index)
          REG_LEARNING_RATE: lr_r  <= cfg_data;
          REG_DIMENSION:     dim_r <= cfg_data[DIMREG_W-1:0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_r   <= in_tuser;
      ra_r    <= in_tdata[9:0];
      rb_r    <= in_tdata[19:10];
      el_r    <= in_tdata[26:20];
      lv_r    <= in_tdata[58:27];
      label_r <= in_tdata[59];
      bias_r  <= in_tdata[91:60];
      rv_r    <= '0;
      step_r  <= '0;
    end
    // fold row numbers into the table, one subtraction a cycle
    if (state_r == S_RED) begin
      if (red_a) ra_r <= ra_r - NODE_W'(NODE_COUNT);
      if (red_b) rb_r <= rb_r - NODE_W'(NODE_COUNT);
    end
    if (state_r == S_BASE) begin
      base_a_r <= ADDR_W'(ra_r) * ADDR_W'(DIM_MAX);
      base_b_r <= ADDR_W'(rb_r) * ADDR_W'(DIM_MAX);
      dlen_r   <= dlen_nxt;
      cnt_r    <= '0;
      acc_r    <= -{{(ACC_W-WORD_W){bias_r[WORD_W-1]}}, bias_r};
    end else if (state_r == S_STEPW || (state_r == S_TGT && done)) begin
      cnt_r <= '0;
    end else if (issue) begin
      cnt_r <= cnt_r + 1'b1;
    end
    if (state_r == S_RWAIT) begin
      rv_r <= el_ok ? q_a : '0;
    end
    if (state_r == S_SIG && sig_valid) begin
      diff_r <= (label_r ? 18'h10000 : 18'h0) - {1'b0, sig_value};
    end
    if (state_r == S_STEPW) begin
      step_r <= prod_r[41:16];
    end
    p1_pass_r <= pass_cur;
    p1_c_r    <= cnt_r;
    p2_pass_r <= p1_pass_r;
    p2_c_r    <= p1_c_r;
    prod_r    <= prod;
    add_r     <= (p1_pass_r == P_TGT) ? q_b : q_a;
    if (p2_v_r && p2_pass_r == P_DOT) begin
      acc_r <= acc_r + {{(ACC_W-40){sh[39]}}, sh};
    end
    if (state_r == S_FIN && fin_go) begin
      out_read_r <= rv_r;
      out_step_r <= step_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{(OUT_DATA_W-WORD_W-STEP_W){1'b0}}, out_step_r, out_read_r};

  epsu_ram #(
    .WIDTH (WORD_W),
    .DEPTH (DEPTH),
    .ADDR_W(ADDR_W)
  ) u_ram (
    .clk    (clk),
    .we     (we),
    .waddr  (wr_addr),
    .wdata  (wr_data),
    .raddr_a(rd_addr_a),
    .raddr_b(rd_addr_b),
    .rdata_a(q_a),
    .rdata_b(q_b)
  );

  epsu_sigmoid #(
    .SIGMOID_ENTRIES(SIGMOID_ENTRIES),
    .ACC_W          (ACC_W)
  ) u_sigmoid (
    .clk  (clk),
    .rst_n(rst_n),
    .start(sig_start),
    .score(acc_r),
    .valid(sig_valid),
    .value(sig_value)
  );

endmodule

`default_nettype wire

/* tb/epsu_checker.sv */
// Scoreboard for the embedding pair update engine: watches the three channels,
// predicts each result from its own copy of the table and registers, and compares.
// Depends on epsu_pkg for widths and codes.
`default_nettype none

module epsu_checker (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  input  logic                              in_tready,
  input  logic [epsu_pkg::IN_DATA_W-1:0]    in_tdata,
  input  logic [epsu_pkg::CMD_W-1:0]        in_tuser,
  input  logic                              out_tvalid,
  input  logic                              out_tready,
  input  logic [epsu_pkg::OUT_DATA_W-1:0]   out_tdata,
  input  logic                              cfg_valid,
  input  logic                              cfg_ready,
  input  logic [epsu_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [epsu_pkg::CFG_DATA_W-1:0]   cfg_data,
  output int                                fail_count,
  output int                                pending
);
  timeunit 1ns;
  timeprecision 1ps;
  import epsu_pkg::*;

  localparam int  ROWS    = NODE_COUNT_DEF;
  localparam int  COLS    = DIM_MAX_DEF;
  localparam int  ENTRIES = SIGMOID_ENTRIES_DEF;
  localparam longint EXP_UNIT = 64'sd1 << 31;

  typedef struct packed {
    logic [STEP_W-1:0] step_scale;
    logic [WORD_W-1:0] read_value;
  } result_t;

  result_t             expected_q[$];
  logic signed [31:0]  weights [0:ROWS*COLS-1];
  longint              sig_rom [0:ENTRIES-1];
  logic [LR_W-1:0]     lr_shadow;
  logic [DIMREG_W-1:0] dim_shadow;
  int                  errors;

  // sigmoid table: short series for exp(-|x|/64), then squared six times
  initial begin
    longint x, y, u, t, e, den;
    for (int k = 0; k < ENTRIES; k++) begin
      x = ((longint'(12 * k)) << 31) / ENTRIES - 6 * EXP_UNIT;
      y = (x < 0) ? -x : x;
      u = y >> 6;
      t = EXP_UNIT;
      e = EXP_UNIT;
      for (int i = 1; i <= 6; i++) begin
        t = ((t * u) >> 31) / i;
        if (i % 2 == 1) e = e - t;
        else e = e + t;
      end
      for (int i = 0; i < 6; i++) e = (e * e) >> 31;
      den = EXP_UNIT + e;
      if (x >= 0) sig_rom[k] = ((EXP_UNIT << 16) + den / 2) / den;
      else sig_rom[k] = ((e << 16) + den / 2) / den;
    end
  end

  function automatic logic signed [31:0] clip32(longint v);
    if (v > 64'sd2147483647) return 32'sh7fffffff;
    if (v < -64'sd2147483648) return 32'sh80000000;
    return v[31:0];
  endfunction

  function automatic longint sigmoid_of(longint score);
    longint k;
    if (score > SCORE_BOUND) return 65536;
    if (score < -SCORE_BOUND) return 0;
    k = (score + SCORE_BOUND) * ENTRIES / (2 * SCORE_BOUND);
    if (k >= ENTRIES) k = ENTRIES - 1;
    return sig_rom[k];
  endfunction

  task automatic predict_item(input logic [CMD_W-1:0] cmd,
                              input logic [IN_DATA_W-1:0] d);
    result_t r;
    int src, dst, n;
    longint score, step, sig;
    logic signed [31:0] bias;
    src = int'(d[9:0]) * COLS;
    dst = int'(d[19:10]) * COLS;
    bias = d[91:60];
    r = '0;
    case (cmd)
      CMD_LOAD: weights[src + int'(d[26:20])] = d[58:27];
      CMD_READ: r.read_value = weights[src + int'(d[26:20])];
      CMD_UPDATE: begin
        n = (dim_shadow > COLS) ? COLS : int'(dim_shadow);
        score = -longint'(bias);
        for (int c = 0; c < n; c++)
          score += (longint'(weights[src + c]) * longint'(weights[dst + c])) >>> 24;
        sig = sigmoid_of(score);
        step = (((d[59] ? 64'sd65536 : 64'sd0) - sig) * longint'(lr_shadow)) >>> 16;
        // target first, then source against the new target
        for (int c = 0; c < n; c++)
          weights[dst + c] = clip32(longint'(weights[dst + c]) +
                                    ((step * longint'(weights[src + c])) >>> 24));
        for (int c = 0; c < n; c++)
          weights[src + c] = clip32(longint'(weights[src + c]) +
                                    ((step * longint'(weights[dst + c])) >>> 24));
        r.step_scale = step[STEP_W-1:0];
      end
      default: ;
    endcase
    expected_q.insert(expected_q.size(), r);
  endtask

  always @(posedge clk) begin
    result_t want, got;
    if (!rst_n) begin
      lr_shadow  = LR_RESET;
      dim_shadow = DIM_RESET;
      expected_q.delete();
      errors = 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == REG_LEARNING_RATE) lr_shadow = cfg_data[LR_W-1:0];
        else if (cfg_index == REG_DIMENSION) dim_shadow = cfg_data[DIMREG_W-1:0];
      end
      if (out_tvalid && out_tready) begin
        got = out_tdata[WORD_W+STEP_W-1:0];
        if (expected_q.size() == 0) begin
          $error("unexpected result item %h", out_tdata);
          errors++;
        end else begin
          want = expected_q.pop_front();
          if (got.read_value !== want.read_value) begin
            $error("read_value: expected %h, got %h", want.read_value, got.read_value);
            errors++;
          end
          if (got.step_scale !== want.step_scale) begin
            $error("step_scale: expected %h, got %h", want.step_scale, got.step_scale);
            errors++;
          end
        end
      end
      if (in_tvalid && in_tready) predict_item(in_tuser, in_tdata);
    end
    fail_count <= errors;
    pending    <= expected_q.size();
  end

endmodule

`default_nettype wire

/* tb/tb_top.sv */
// Top of the embedding pair update bench: clock, reset, stimulus and verdict.
// Depends on epsu_pkg, the block and epsu_checker.
`default_nettype none

module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import epsu_pkg::*;

  localparam int IDLE_LIMIT = 4000;
  localparam int RANDOM_PER_PHASE = 80;

  logic                  clk;
  logic                  rst_n;
  logic                  in_tvalid;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata;
  logic [CMD_W-1:0]      in_tuser;
  logic                  out_tvalid;
  logic                  out_tready;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;
  int                    fail_count;
  int                    pending;

  bit        written [0:1023][0:127];
  bit        calm;
  bit        long_hold;
  int        idle_cycles;
  int        node_pool [8] = '{0, 1023, 5, 77, 300, 512, 640, 900};

  embedding_pair_sgd_update dut (.*);

  epsu_checker scoreboard (.*);

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    in_tvalid  = 1'b0;
    in_tdata   = '0;
    in_tuser   = '0;
    out_tready = 1'b0;
    cfg_valid  = 1'b0;
    cfg_index  = '0;
    cfg_data   = '0;
    calm       = 1'b0;
    long_hold  = 1'b0;
    rst_n      = 1'b0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
  end

  function automatic int gap_len();
    int r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // receiver: random stalls, plus one long hold-off on request
  initial begin
    int n;
    @(posedge clk iff rst_n);
    forever begin
      if (long_hold) begin
        out_tready <= 1'b0;
        repeat (700) @(posedge clk);
        long_hold = 1'b0;
      end else begin
        n = gap_len();
        if (n > 0) begin
          out_tready <= 1'b0;
          repeat (n) @(posedge clk);
        end
      end
      out_tready <= 1'b1;
      @(posedge clk);
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || (cfg_valid && cfg_ready))
        idle_cycles <= 0;
      else
        idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("FAIL embedding_pair_sgd_update");
        $finish;
      end
    end else begin
      idle_cycles <= 0;
    end
  end

  task automatic send_item(input logic [CMD_W-1:0] cmd, input int a, input int b,
                           input int el, input logic [31:0] value, input bit lab,
                           input logic [31:0] bias);
    int n;
    n = gap_len();
    if (n > 0) begin
      in_tvalid <= 1'b0;
      repeat (n) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= cmd;
    in_tdata  <= {4'b0, bias, lab, value, el[6:0], b[9:0], a[9:0]};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    if (cmd == CMD_LOAD) written[a][el] = 1'b1;
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value[CFG_DATA_W-1:0];
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic drain();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  function automatic logic [31:0] weight_value();
    int r;
    r = $urandom_range(0, 99);
    if (r < 80) return 32'($urandom_range(0, 16777216)) - 32'd8388608;
    if (r < 92) return $urandom;
    return r[0] ? 32'h7fffffff : 32'h80000000;
  endfunction

  function automatic logic [31:0] bias_value();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return 32'($urandom_range(0, 268435456)) - 32'd134217728;
    if (r < 85) return $urandom;
    if (r < 90) return 32'd100663296;
    if (r < 95) return -32'd100663296;
    return 32'd0;
  endfunction

  task automatic fill_rows(input int used, input int npool);
    for (int p = 0; p < npool; p++)
      for (int c = 0; c < used; c++)
        if (!written[node_pool[p]][c])
          send_item(CMD_LOAD, node_pool[p], 0, c, weight_value(), 1'b0, 32'd0);
  endtask

  task automatic random_item(input int npool);
    int r, a, el;
    r  = $urandom_range(0, 99);
    a  = node_pool[$urandom_range(0, npool - 1)];
    el = $urandom_range(0, 127);
    if (r < 5) begin
      send_item(2'd3, $urandom_range(0, 1023), $urandom_range(0, 1023), el, $urandom,
                $urandom_range(0, 1), $urandom);
    end else if (r < 25 || (r < 45 && !written[a][el])) begin
      send_item(CMD_LOAD, a, 0, el, weight_value(), 1'b0, 32'd0);
    end else if (r < 45) begin
      send_item(CMD_READ, a, 0, el, 32'd0, 1'b0, 32'd0);
    end else begin
      send_item(CMD_UPDATE, a, node_pool[$urandom_range(0, npool - 1)], 0, 32'd0,
                $urandom_range(0, 1), bias_value());
    end
  endtask

  initial begin
    int lr_set  [6] = '{41943, 16777215, 0, 1048576, 0, 100000};
    int dim_set [6] = '{8, 4, 2, 16, 1, 255};
    int pool_set[6] = '{8, 8, 6, 8, 8, 2};
    int used;
    @(posedge clk iff rst_n);

    // directed part
    write_reg(REG_DIMENSION, 3);
    send_item(CMD_LOAD, 0, 0, 0, 32'h7fffffff, 1'b0, 32'd0);
    send_item(CMD_LOAD, 0, 0, 1, 32'h80000000, 1'b0, 32'd0);
    send_item(CMD_LOAD, 0, 0, 2, 32'h01000000, 1'b0, 32'd0);
    send_item(CMD_LOAD, 1023, 0, 0, 32'h00800000, 1'b0, 32'd0);
    send_item(CMD_LOAD, 1023, 0, 1, 32'hff400000, 1'b0, 32'd0);
    send_item(CMD_LOAD, 1023, 0, 2, 32'h00100000, 1'b0, 32'd0);
    send_item(CMD_LOAD, 1023, 0, 127, 32'hffffffff, 1'b0, 32'd0);
    send_item(CMD_READ, 0, 0, 1, 32'd0, 1'b0, 32'd0);
    send_item(CMD_READ, 1023, 0, 127, 32'd0, 1'b0, 32'd0);
    send_item(CMD_UPDATE, 1023, 1023, 0, 32'd0, 1'b1, 32'd0);
    send_item(CMD_UPDATE, 0, 1023, 0, 32'd0, 1'b1, 32'h7fffffff);
    send_item(CMD_UPDATE, 1023, 0, 0, 32'd0, 1'b0, 32'h80000000);
    send_item(CMD_UPDATE, 0, 0, 0, 32'd0, 1'b0, 32'd0);
    send_item(2'd3, 1023, 1023, 127, 32'hffffffff, 1'b1, 32'hffffffff);
    send_item(CMD_READ, 0, 0, 0, 32'd0, 1'b0, 32'd0);
    drain();
    // no elements in use: score is the negated bias, exactly +6.0 and then -6.0 here
    write_reg(REG_DIMENSION, 0);
    send_item(CMD_UPDATE, 5, 77, 0, 32'd0, 1'b1, -32'd100663296);
    send_item(CMD_UPDATE, 5, 77, 0, 32'd0, 1'b0, 32'd100663296);
    drain();
    write_reg(REG_DIMENSION, 3);
    write_reg(REG_LEARNING_RATE, 0);
    send_item(CMD_UPDATE, 0, 1023, 0, 32'd0, 1'b1, 32'd0);
    drain();
    write_reg(REG_LEARNING_RATE, 24'hffffff);
    send_item(CMD_UPDATE, 1023, 0, 0, 32'd0, 1'b0, 32'hff000000);
    send_item(CMD_READ, 1023, 0, 2, 32'd0, 1'b0, 32'd0);
    drain();

    // random phases, one register setting each
    for (int ph = 0; ph < 6; ph++) begin
      write_reg(REG_LEARNING_RATE, lr_set[ph] == 0 && ph == 4 ?
                int'($urandom_range(1, 24'hffffff)) : lr_set[ph]);
      write_reg(REG_DIMENSION, dim_set[ph]);
      used = (dim_set[ph] > 128) ? 128 : dim_set[ph];
      calm = (ph == 3);
      fill_rows(used, pool_set[ph]);
      if (ph == 1) long_hold = 1'b1;
      for (int i = 0; i < RANDOM_PER_PHASE; i++) random_item(pool_set[ph]);
      drain();
    end

    repeat (500) @(posedge clk);
    if (fail_count == 0) begin
      $display("PASS embedding_pair_sgd_update");
    end else begin
      $display("FAIL embedding_pair_sgd_update");
    end
    $finish;
  end

endmodule

`default_nettype wire

/* files.f */
design/epsu_pkg.sv
design/epsu_ram.sv
design/epsu_sigmoid.sv
design/embedding_pair_sgd_update.sv
tb/epsu_checker.sv
tb/tb_top.sv
